>>> design/rpf_pkg.sv
package rpf_pkg;

    localparam int TRACKED_NODES = 10;
    localparam int WINDOW_DEPTH  = 16;

    localparam int ID_W  = 48;
    localparam int SEQ_W = 16;
    localparam int GAP_W = 15;

    localparam logic [GAP_W-1:0] GAP_RESET = 15'd100;

    // slot index, and a counter wide enough to hold the slot count itself
    localparam int NODE_W  = (TRACKED_NODES > 1) ? $clog2(TRACKED_NODES) : 1;
    localparam int NODE_CW = $clog2(TRACKED_NODES + 1);

    // window position, and a count that can hold the window depth itself
    localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    localparam int WIN_ENTRIES = TRACKED_NODES * WINDOW_DEPTH;
    localparam int WIN_AW      = (WIN_ENTRIES > 1) ? $clog2(WIN_ENTRIES) : 1;

    // sender id table port
    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [ID_W-1:0]   wdata;
        logic [NODE_W-1:0] raddr;
    } id_port_t;

    // sequence window store port
    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [SEQ_W-1:0]  wdata;
        logic [WIN_AW-1:0] raddr;
    } win_port_t;

endpackage

>>> design/rpf_ram.sv
module rpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rpf_ctrl.sv
module rpf_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [rpf_pkg::ID_W-1:0]         sender_id,
    input  logic [rpf_pkg::SEQ_W-1:0]        seq_num,
    input  logic [rpf_pkg::GAP_W-1:0]        gap,
    input  logic [rpf_pkg::ID_W-1:0]         id_rdata,
    input  logic [rpf_pkg::SEQ_W-1:0]        win_rdata,
    output rpf_pkg::id_port_t                id_port,
    output rpf_pkg::win_port_t               win_port,
    output logic                             busy,
    output logic                             done,
    output logic                             fresh
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WSCAN,
        S_GAP,
        S_APPEND
    } state_t;

    state_t state_reg, state_next;

    logic [rpf_pkg::ID_W-1:0]    id_reg, id_next;
    logic [rpf_pkg::SEQ_W-1:0]   seq_reg, seq_next;
    logic [rpf_pkg::NODE_W-1:0]  slot_reg, slot_next;
    logic [rpf_pkg::NODE_CW-1:0] node_iss_reg, node_iss_next;
    logic [rpf_pkg::CNT_W-1:0]   pos_iss_reg, pos_iss_next;
    logic                        chk_reg, chk_next;
    logic                        empty_found_reg, empty_found_next;
    logic [rpf_pkg::NODE_W-1:0]  empty_idx_reg, empty_idx_next;
    logic [rpf_pkg::CNT_W-1:0]   cur_cnt_reg, cur_cnt_next;
    logic [rpf_pkg::POS_W-1:0]   cur_head_reg, cur_head_next;
    logic [rpf_pkg::POS_W-1:0]   newest_reg, newest_next;
    logic [rpf_pkg::SEQ_W-1:0]   last_reg, last_next;
    logic                        done_reg, done_next;
    logic                        fresh_reg, fresh_next;

    // per-slot fill count (zero means slot free) and ring head
    logic [rpf_pkg::CNT_W-1:0]   counts_reg [rpf_pkg::TRACKED_NODES];
    logic [rpf_pkg::POS_W-1:0]   heads_reg  [rpf_pkg::TRACKED_NODES];

    logic                        slot_we;
    logic [rpf_pkg::NODE_W-1:0]  slot_waddr;
    logic [rpf_pkg::CNT_W-1:0]   slot_cnt_wdata;
    logic [rpf_pkg::POS_W-1:0]   slot_head_wdata;

    logic [rpf_pkg::NODE_CW-1:0] look_cnt;
    logic [rpf_pkg::NODE_W-1:0]  look_idx;
    logic [rpf_pkg::CNT_W-1:0]   look_slot_cnt;
    logic [rpf_pkg::POS_W-1:0]   look_slot_head;
    logic [rpf_pkg::NODE_W-1:0]  claim_idx;
    logic [rpf_pkg::CNT_W-1:0]   chk_pos;
    logic [rpf_pkg::CNT_W-1:0]   cnt_m1;
    logic [rpf_pkg::POS_W-1:0]   head_p1;
    logic [rpf_pkg::POS_W-1:0]   app_pos;
    logic                        win_full;
    logic [rpf_pkg::WIN_AW-1:0]  win_base;
    logic [rpf_pkg::SEQ_W-1:0]   diff;
    logic [rpf_pkg::SEQ_W:0]     diff_ext;
    logic [rpf_pkg::SEQ_W:0]     neg_gap;
    logic                        gap_fail;

    assign look_cnt       = node_iss_reg - rpf_pkg::NODE_CW'(1);
    assign look_idx       = look_cnt[rpf_pkg::NODE_W-1:0];
    assign look_slot_cnt  = counts_reg[look_idx];
    assign look_slot_head = heads_reg[look_idx];
    assign chk_pos        = pos_iss_reg - rpf_pkg::CNT_W'(1);
    assign cnt_m1         = cur_cnt_reg - rpf_pkg::CNT_W'(1);
    assign win_full       = (cur_cnt_reg == rpf_pkg::CNT_W'(rpf_pkg::WINDOW_DEPTH));
    assign head_p1        = (cur_head_reg == rpf_pkg::POS_W'(rpf_pkg::WINDOW_DEPTH - 1)) ? '0
                                                 : cur_head_reg + rpf_pkg::POS_W'(1);
    assign app_pos        = win_full ? cur_head_reg : cur_cnt_reg[rpf_pkg::POS_W-1:0];
    assign win_base       = rpf_pkg::WIN_AW'(slot_reg) *
                            rpf_pkg::WIN_AW'(rpf_pkg::WINDOW_DEPTH);

    // wrapped difference as two's complement, against minus the gap
    assign diff     = seq_reg - last_reg;
    assign diff_ext = {diff[rpf_pkg::SEQ_W-1], diff};
    assign neg_gap  = (rpf_pkg::SEQ_W + 1)'(0) - {2'b00, gap};
    assign gap_fail = ($signed(diff_ext) < $signed(neg_gap));

    // lowest free slot seen so far including the current one, else slot 0
    always_comb
    begin
        if (empty_found_reg)
        begin
            claim_idx = empty_idx_reg;
        end
        else if (look_slot_cnt == '0)
        begin
            claim_idx = look_idx;
        end
        else
        begin
            claim_idx = '0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        id_next          = id_reg;
        seq_next         = seq_reg;
        slot_next        = slot_reg;
        node_iss_next    = node_iss_reg;
        pos_iss_next     = pos_iss_reg;
        chk_next         = 1'b0;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        cur_cnt_next     = cur_cnt_reg;
        cur_head_next    = cur_head_reg;
        newest_next      = newest_reg;
        last_next        = last_reg;
        done_next        = 1'b0;
        fresh_next       = fresh_reg;

        slot_we          = 1'b0;
        slot_waddr       = slot_reg;
        slot_cnt_wdata   = '0;
        slot_head_wdata  = '0;

        id_port.we       = 1'b0;
        id_port.waddr    = claim_idx;
        id_port.wdata    = id_reg;
        id_port.raddr    = node_iss_reg[rpf_pkg::NODE_W-1:0];

        win_port.we      = 1'b0;
        win_port.waddr   = win_base + rpf_pkg::WIN_AW'(app_pos);
        win_port.wdata   = seq_reg;
        win_port.raddr   = win_base + rpf_pkg::WIN_AW'(pos_iss_reg[rpf_pkg::POS_W-1:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next          = sender_id;
                    seq_next         = seq_num;
                    node_iss_next    = '0;
                    empty_found_next = 1'b0;
                    empty_idx_next   = '0;
                    state_next       = S_LOOK;
                end
            end

            S_LOOK:
            begin
                // one id read issued per cycle, compared the cycle after
                if (node_iss_reg < rpf_pkg::NODE_CW'(rpf_pkg::TRACKED_NODES))
                begin
                    node_iss_next = node_iss_reg + rpf_pkg::NODE_CW'(1);
                    chk_next      = 1'b1;
                end
                if (chk_reg)
                begin
                    if (look_slot_cnt != '0 && id_rdata == id_reg)
                    begin
                        slot_next     = look_idx;
                        cur_cnt_next  = look_slot_cnt;
                        cur_head_next = look_slot_head;
                        if (look_slot_cnt < rpf_pkg::CNT_W'(rpf_pkg::WINDOW_DEPTH))
                        begin
                            newest_next = look_slot_cnt[rpf_pkg::POS_W-1:0]
                                          - rpf_pkg::POS_W'(1);
                        end
                        else if (look_slot_head == '0)
                        begin
                            newest_next = rpf_pkg::POS_W'(rpf_pkg::WINDOW_DEPTH - 1);
                        end
                        else
                        begin
                            newest_next = look_slot_head - rpf_pkg::POS_W'(1);
                        end
                        pos_iss_next  = '0;
                        chk_next      = 1'b0;
                        state_next    = S_WSCAN;
                    end
                    else if (look_idx == rpf_pkg::NODE_W'(rpf_pkg::TRACKED_NODES - 1))
                    begin
                        // miss: claim a slot, its window starts empty
                        id_port.we      = 1'b1;
                        slot_we         = 1'b1;
                        slot_waddr      = claim_idx;
                        slot_next       = claim_idx;
                        cur_cnt_next    = '0;
                        cur_head_next   = '0;
                        chk_next        = 1'b0;
                        state_next      = S_APPEND;
                    end
                    else if (look_slot_cnt == '0 && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = look_idx;
                    end
                end
            end

            S_WSCAN:
            begin
                if (pos_iss_reg < cur_cnt_reg)
                begin
                    pos_iss_next = pos_iss_reg + rpf_pkg::CNT_W'(1);
                    chk_next     = 1'b1;
                end
                if (chk_reg)
                begin
                    if (chk_pos[rpf_pkg::POS_W-1:0] == newest_reg)
                    begin
                        last_next = win_rdata;
                    end
                    if (win_rdata == seq_reg)
                    begin
                        done_next  = 1'b1;
                        fresh_next = 1'b0;
                        chk_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (chk_pos == cnt_m1)
                    begin
                        chk_next   = 1'b0;
                        state_next = S_GAP;
                    end
                end
            end

            S_GAP:
            begin
                if (gap_fail)
                begin
                    done_next  = 1'b1;
                    fresh_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end

            S_APPEND:
            begin
                win_port.we = 1'b1;
                slot_we     = 1'b1;
                if (win_full)
                begin
                    slot_cnt_wdata  = cur_cnt_reg;
                    slot_head_wdata = head_p1;
                end
                else
                begin
                    slot_cnt_wdata  = cur_cnt_reg + rpf_pkg::CNT_W'(1);
                    slot_head_wdata = cur_head_reg;
                end
                done_next  = 1'b1;
                fresh_next = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            node_iss_reg    <= '0;
            pos_iss_reg     <= '0;
            chk_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            slot_reg        <= '0;
            cur_cnt_reg     <= '0;
            cur_head_reg    <= '0;
            newest_reg      <= '0;
            done_reg        <= 1'b0;
            fresh_reg       <= 1'b0;
            for (int i = 0; i < rpf_pkg::TRACKED_NODES; i++)
            begin
                counts_reg[i] <= '0;
                heads_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            node_iss_reg    <= node_iss_next;
            pos_iss_reg     <= pos_iss_next;
            chk_reg         <= chk_next;
            empty_found_reg <= empty_found_next;
            empty_idx_reg   <= empty_idx_next;
            slot_reg        <= slot_next;
            cur_cnt_reg     <= cur_cnt_next;
            cur_head_reg    <= cur_head_next;
            newest_reg      <= newest_next;
            done_reg        <= done_next;
            fresh_reg       <= fresh_next;
            if (slot_we)
            begin
                counts_reg[slot_waddr] <= slot_cnt_wdata;
                heads_reg[slot_waddr]  <= slot_head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        seq_reg  <= seq_next;
        last_reg <= last_next;
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign fresh = fresh_reg;

endmodule

>>> design/per_node_replay_filter_core.sv
// Channel   Handshake            Payload                Direction
// -------   ------------------   --------------------   ---------
// item in   start & !busy        sender_id, seq_num     in
// result    done (1-cycle pulse) fresh                  out
// config    cfg_we               cfg_wdata (gap, 15b)   in
//
// One item at a time. A new sender walks the whole id table and then
// appends; a known one walks the id table up to its slot, then its window,
// then takes the gap check and the append unless a match or a failed gap
// check ends it. The walks read one id table or window entry per cycle.
// Reset clears the slot counts at once; no clearing pass is needed.
// done is high for exactly one cycle and cannot be held off.
module per_node_replay_filter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rpf_pkg::ID_W-1:0]      sender_id,
    input  logic [rpf_pkg::SEQ_W-1:0]     seq_num,
    output logic                          done,
    output logic                          fresh,
    input  logic                          cfg_we,
    input  logic [rpf_pkg::GAP_W-1:0]     cfg_wdata
);

    // largest backward step allowed from the newest accepted number
    logic [rpf_pkg::GAP_W-1:0] gap_reg;

    rpf_pkg::id_port_t         id_port;
    rpf_pkg::win_port_t        win_port;
    logic [rpf_pkg::ID_W-1:0]  id_rdata;
    logic [rpf_pkg::SEQ_W-1:0] win_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= rpf_pkg::GAP_RESET;
        end
        else if (cfg_we)
        begin
            gap_reg <= cfg_wdata;
        end
    end

    // sender id per slot; an entry is only trusted when its count is nonzero
    rpf_ram #(
        .WIDTH (rpf_pkg::ID_W),
        .DEPTH (rpf_pkg::TRACKED_NODES)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_port.we),
        .waddr (id_port.waddr),
        .wdata (id_port.wdata),
        .raddr (id_port.raddr),
        .rdata (id_rdata)
    );

    // sequence windows, WINDOW_DEPTH entries per slot, ring per slot once full
    rpf_ram #(
        .WIDTH (rpf_pkg::SEQ_W),
        .DEPTH (rpf_pkg::WIN_ENTRIES)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_port.we),
        .waddr (win_port.waddr),
        .wdata (win_port.wdata),
        .raddr (win_port.raddr),
        .rdata (win_rdata)
    );

    // lookup, window scan, gap check and append sequencer
    rpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .sender_id (sender_id),
        .seq_num   (seq_num),
        .gap       (gap_reg),
        .id_rdata  (id_rdata),
        .win_rdata (win_rdata),
        .id_port   (id_port),
        .win_port  (win_port),
        .busy      (busy),
        .done      (done),
        .fresh     (fresh)
    );

endmodule

>>> design/rpf_checker.sv
module rpf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in progress");

    // one result per item: no two in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

    // the result is shown as the block goes idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    // busy only rises on an accepted item
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a start");

endmodule

bind per_node_replay_filter_core rpf_checker u_rpf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
